// ===== rtl/rspt_pkg.sv =====
package rspt_pkg;

    localparam int IDX_W         = 24;
    localparam int KEY_W         = 8;
    localparam int PD_W          = 16;
    localparam int RIGHTS_W      = 8;
    localparam int ADDR64_W      = 64;
    localparam int DEFAULT_DEPTH = 1024;

    localparam logic [RIGHTS_W-1:0] RIGHTS_MASK_RESET = 8'hFF;

    localparam logic [2:0] MODE_REGISTER   = 3'd0;
    localparam logic [2:0] MODE_VALIDATE   = 3'd1;
    localparam logic [2:0] MODE_INVALIDATE = 3'd2;
    localparam logic [2:0] MODE_DROP       = 3'd3;
    localparam logic [2:0] MODE_CHECK      = 3'd4;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_STAG_INVAL = 3'd1;
    localparam logic [2:0] STATUS_PD_MISMATCH = 3'd2;
    localparam logic [2:0] STATUS_PERM_DENIED = 3'd3;
    localparam logic [2:0] STATUS_OUT_OF_BND = 3'd4;
    localparam logic [2:0] STATUS_UNKNOWN    = 3'd5;
    localparam logic [2:0] STATUS_UNUSABLE   = 3'd6;

    // Table entry as stored; limit is base + length, kept at 65 bits
    typedef struct packed {
        logic                  present;
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [PD_W-1:0]       domain;
        logic [RIGHTS_W-1:0]   rights;
        logic [ADDR64_W-1:0]   base;
        logic [ADDR64_W:0]     limit;
    } entry_t;

    // Request context carried from acceptance to evaluation
    typedef struct packed {
        logic [2:0]            mode;
        logic [KEY_W-1:0]      key;
        logic [PD_W-1:0]       pd;
        logic [RIGHTS_W-1:0]   rights;
        logic [ADDR64_W-1:0]   base;
        logic [ADDR64_W-1:0]   len;
        logic                  in_range;
        logic                  elem_bad;
        logic [ADDR64_W:0]     addr;
        logic [ADDR64_W+1:0]   access_end;
        logic [ADDR64_W:0]     limit;
    } ctx_t;

    typedef struct packed {
        logic [2:0]            status;
        logic                  wr_en;
        entry_t                wr_entry;
    } eval_t;

endpackage

// ===== rtl/rdma_stag_protection_table.sv =====
// Flow: the accepted beat is registered, the table is read in S_FETCH, then
// S_EVAL evaluates, writes back through the single table memory and registers
// the result; a stalled result holds evaluation. s_ready stays low until then.
// Reset: synchronous active-low; afterwards a clearing pass writes every table
// entry with s_ready low. cfg writes are taken throughout.
module rdma_stag_protection_table #(
    parameter int TABLE_DEPTH = rspt_pkg::DEFAULT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_stag,
    input  logic [15:0] s_pd_id,
    input  logic [7:0]  s_access_rights,
    input  logic [63:0] s_base_address,
    input  logic [63:0] s_length,
    input  logic [31:0] s_offset,
    input  logic [31:0] s_element_length,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status
);
    import rspt_pkg::*;

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_FETCH = 4'b0100,
        S_EVAL  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]        rights_mask_reg, rights_mask_next;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg, m_status_next;

    ctx_t              ctx_reg, ctx_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    logic [IDX_W-1:0]  s_idx;
    logic              s_fire;
    logic              eval_adv;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_entry;
    eval_t             eval_res;

    assign s_idx    = s_stag[31:8];
    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign eval_adv = (state_reg == S_EVAL) && (!m_valid_reg || m_ready);
    assign rd_entry = entry_t'(ram_rdata);

    rspt_eval u_eval (
        .ctx         (ctx_reg),
        .entry       (rd_entry),
        .rights_mask (rights_mask_reg),
        .res         (eval_res)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = eval_res.wr_entry;
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (eval_adv && eval_res.wr_en) begin
            ram_we = 1'b1;
        end
    end

    assign ram_re = (state_reg == S_FETCH);

    rspt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        rights_mask_next = cfg_wr_en ? cfg_wr_data : rights_mask_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        ctx_next         = ctx_reg;
        idx_next         = idx_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    ctx_next.mode     = s_mode;
                    ctx_next.key      = s_stag[KEY_W-1:0];
                    ctx_next.pd       = s_pd_id;
                    ctx_next.rights   = s_access_rights;
                    ctx_next.base     = s_base_address;
                    ctx_next.len      = s_length;
                    ctx_next.in_range = (s_idx != '0) &&
                        ({1'b0, s_idx} < (IDX_W+1)'(TABLE_DEPTH));
                    ctx_next.elem_bad = ({1'b0, s_length} + 65'(s_offset)) >
                        65'(s_element_length);
                    ctx_next.addr     = {1'b0, s_base_address} + 65'(s_offset);
                    idx_next          = s_idx[ADDR_W-1:0];
                    state_next        = S_FETCH;
                end
            end
            S_FETCH: begin
                // read issued this cycle; form the wide sums alongside it
                ctx_next.access_end = {1'b0, ctx_reg.addr} + 66'(ctx_reg.len);
                ctx_next.limit      = {1'b0, ctx_reg.base} + 65'(ctx_reg.len);
                state_next          = S_EVAL;
            end
            S_EVAL: begin
                if (eval_adv) begin
                    m_valid_next  = 1'b1;
                    m_status_next = eval_res.status;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            rights_mask_reg <= RIGHTS_MASK_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            rights_mask_reg <= rights_mask_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        ctx_reg      <= ctx_next;
        idx_reg      <= idx_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    a_result_from_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_EVAL))
        else $error("result appeared without an evaluation");

    a_no_write_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == S_EVAL) |-> (ctx_reg.in_range && idx_reg != '0))
        else $error("table write to an unusable slot");

    a_register_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == S_EVAL && ctx_reg.mode == MODE_REGISTER)
            |-> (ram_wdata.present && !ram_wdata.valid && !rd_entry.present))
        else $error("register overwrote an occupied entry or set validity");

    a_accept_to_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == S_FETCH && !s_ready))
        else $error("accepted beat did not start a table read");

endmodule

// ===== rtl/rspt_ram.sv =====
module rspt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rspt_eval.sv =====
module rspt_eval (
    input  rspt_pkg::ctx_t   ctx,
    input  rspt_pkg::entry_t entry,
    input  logic [7:0]       rights_mask,
    output rspt_pkg::eval_t  res
);
    import rspt_pkg::*;

    logic present;
    logic perm_bad;
    logic below_base;
    logic past_limit;

    assign present    = ctx.in_range && entry.present;
    assign perm_bad   = (entry.rights & ctx.rights) != ctx.rights;
    assign below_base = ctx.addr < {1'b0, entry.base};
    assign past_limit = ctx.access_end > {1'b0, entry.limit};

    always_comb begin
        res.status   = STATUS_OK;
        res.wr_en    = 1'b0;
        res.wr_entry = entry;
        case (ctx.mode)
            MODE_REGISTER: begin
                if (!ctx.in_range || entry.present) begin
                    res.status = STATUS_UNUSABLE;
                end else begin
                    res.wr_en           = 1'b1;
                    res.wr_entry.present = 1'b1;
                    res.wr_entry.valid  = 1'b0;
                    res.wr_entry.key    = ctx.key;
                    res.wr_entry.domain = ctx.pd;
                    res.wr_entry.rights = ctx.rights & rights_mask;
                    res.wr_entry.base   = ctx.base;
                    res.wr_entry.limit  = ctx.limit;
                end
            end
            MODE_VALIDATE: begin
                if (!present) begin
                    res.status = STATUS_UNKNOWN;
                end else begin
                    res.wr_en          = 1'b1;
                    res.wr_entry.valid = 1'b1;
                end
            end
            MODE_INVALIDATE: begin
                if (!present) begin
                    res.status = STATUS_UNKNOWN;
                end else if (entry.domain != ctx.pd) begin
                    res.status = STATUS_PD_MISMATCH;
                end else begin
                    res.wr_en          = 1'b1;
                    res.wr_entry.valid = 1'b0;
                end
            end
            MODE_DROP: begin
                if (!present) begin
                    res.status = STATUS_UNKNOWN;
                end else begin
                    res.wr_en            = 1'b1;
                    res.wr_entry.present = 1'b0;
                    res.wr_entry.valid   = 1'b0;
                end
            end
            MODE_CHECK: begin
                if (ctx.elem_bad) begin
                    res.status = STATUS_OUT_OF_BND;
                end else if (!present) begin
                    res.status = STATUS_UNKNOWN;
                end else if (entry.key != ctx.key || !entry.valid) begin
                    res.status = STATUS_STAG_INVAL;
                end else if (entry.domain != ctx.pd) begin
                    res.status = STATUS_PD_MISMATCH;
                end else if (perm_bad) begin
                    res.status = STATUS_PERM_DENIED;
                end else if (below_base || past_limit) begin
                    res.status = STATUS_OUT_OF_BND;
                end
            end
            default: begin
                res.status = STATUS_UNUSABLE;
            end
        endcase
    end

endmodule
